### src/ofr_pkg.sv
// Types, codes and reset values shared by the OpenTherm frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package ofr_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned GAP_W   = 16;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 4;

    localparam logic [CNT_W-1:0] FRAME_BITS = 6'd32;

    // input commands; code 3 is unused
    localparam logic [1:0] CMD_EDGE = 2'd0;
    localparam logic [1:0] CMD_POLL = 2'd1;
    localparam logic [1:0] CMD_ARM  = 2'd2;

    // report codes
    localparam logic [1:0] OUT_SUCCESS = 2'd0;
    localparam logic [1:0] OUT_INVALID = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;

    // message type field, bits 30..28 of the frame
    localparam logic [2:0] MSG_REQ_LO = 3'd0;
    localparam logic [2:0] MSG_REQ_HI = 3'd1;
    localparam logic [2:0] MSG_RSP_LO = 3'd4;
    localparam logic [2:0] MSG_RSP_HI = 3'd5;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_LISTEN  = 2'd0;
    localparam logic [1:0] REG_BIT_GAP = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_QUIET   = 2'd3;

    localparam logic [GAP_W-1:0]  RST_BIT_GAP = 16'd750;
    localparam logic [TIME_W-1:0] RST_TIMEOUT = 32'd1000000;
    localparam logic [TIME_W-1:0] RST_QUIET   = 32'd100000;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WAIT    = 3'd1,
        PH_START   = 3'd2,
        PH_RECV    = 3'd3,
        PH_INVALID = 3'd4,
        PH_DONE    = 3'd5,
        PH_DELAY   = 3'd6
    } t_phase;

    typedef struct packed {
        logic              listen;
        logic [GAP_W-1:0]  bit_gap;
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] quiet;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [TIME_W-1:0] last_time;
        logic [31:0]       shift_frame;
        logic [CNT_W-1:0]  bit_count;
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] frame;
        logic [1:0]  outcome;
    } t_result;

endpackage

`default_nettype wire

### src/opentherm_frame_receiver.sv
// Top level of the OpenTherm frame receiver: event register, state and result register.
//
// Events (line edge, poll tick, arm) come in one per transfer with a microsecond
// timestamp, and one can be taken every clock cycle. Each event is held in the input
// register while the receive state and, for a poll that reports, the result register
// are updated, so a report passes the input register and then the result register. The
// input side stalls only when a report is due while the previous one is still held on
// a stalled output; events that give no report pass even then. Only polls give reports.
// Registers sit at byte addresses 0, 4, 8 and 12 and should be written while no event
// is in flight.
`timescale 1ns / 1ps
`default_nettype none

module opentherm_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // event input
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic                        i_level,
    input  wire logic [ofr_pkg::TIME_W-1:0]  i_time_us,
    // report output
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [31:0]                 o_frame,
    output logic      [1:0]                  o_outcome,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ofr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ofr_pkg::DATA_W-1:0]  pwdata,
    output logic      [ofr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    ofr_pkg::t_cfg    cfg;
    ofr_pkg::t_state  r_state;
    ofr_pkg::t_state  n_state;
    ofr_pkg::t_result step_res;

    logic                        r_in_valid;
    logic [1:0]                  r_cmd;
    logic                        r_level;
    logic [ofr_pkg::TIME_W-1:0]  r_time_us;

    logic                        r_out_valid;
    logic [31:0]                 r_frame;
    logic [1:0]                  r_outcome;

    logic                        in_take;
    logic                        advance;

    ofr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ofr_step u_step (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_cmd     (r_cmd),
        .i_level   (r_level),
        .i_time_us (r_time_us),
        .o_state   (n_state),
        .o_result  (step_res)
    );

    // the held event moves on unless it reports into an occupied, stalled output
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall || !step_res.valid);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.phase         <= ofr_pkg::PH_IDLE;
            r_state.last_time     <= '0;
            r_state.shift_frame   <= '0;
            r_state.bit_count     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && step_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd     <= i_cmd;
            r_level   <= i_level;
            r_time_us <= i_time_us;
        end
        if (advance && step_res.valid) begin
            r_frame   <= step_res.frame;
            r_outcome <= step_res.outcome;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_frame     = r_frame;
    assign o_outcome   = r_outcome;

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_count <= ofr_pkg::FRAME_BITS)
        else $error("bit count beyond frame length");

    a_report_leaves_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.valid |=>
            (r_state.phase == ofr_pkg::PH_DELAY || r_state.phase == ofr_pkg::PH_IDLE))
        else $error("report did not move to delay or idle");

    a_success_even_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outcome == ofr_pkg::OUT_SUCCESS |-> !(^o_frame))
        else $error("successful frame with odd parity");

    a_count_only_in_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_state.bit_count) |->
            $past(r_state.phase) == ofr_pkg::PH_START ||
            $past(r_state.phase) == ofr_pkg::PH_RECV)
        else $error("bit count changed outside reception");

    a_no_report_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid)
        else $error("held report dropped while stalled");

endmodule

`default_nettype wire

### src/ofr_apb_regs.sv
// APB configuration registers of the OpenTherm frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module ofr_apb_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ofr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ofr_pkg::DATA_W-1:0]  pwdata,
    output logic      [ofr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output ofr_pkg::t_cfg                    o_cfg
);

    ofr_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen  <= 1'b0;
            r_cfg.bit_gap <= ofr_pkg::RST_BIT_GAP;
            r_cfg.timeout <= ofr_pkg::RST_TIMEOUT;
            r_cfg.quiet   <= ofr_pkg::RST_QUIET;
        end else if (wr_en) begin
            unique case (reg_idx)
                ofr_pkg::REG_LISTEN:  r_cfg.listen  <= pwdata[0];
                ofr_pkg::REG_BIT_GAP: r_cfg.bit_gap <= pwdata[ofr_pkg::GAP_W-1:0];
                ofr_pkg::REG_TIMEOUT: r_cfg.timeout <= pwdata;
                ofr_pkg::REG_QUIET:   r_cfg.quiet   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ofr_pkg::REG_LISTEN:  prdata = {31'd0, r_cfg.listen};
            ofr_pkg::REG_BIT_GAP: prdata = {16'd0, r_cfg.bit_gap};
            ofr_pkg::REG_TIMEOUT: prdata = r_cfg.timeout;
            ofr_pkg::REG_QUIET:   prdata = r_cfg.quiet;
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### src/ofr_step.sv
// Next-state and report logic for one edge, poll or arm event.
`timescale 1ns / 1ps
`default_nettype none

module ofr_step (
    input  wire ofr_pkg::t_cfg               i_cfg,
    input  wire ofr_pkg::t_state             i_state,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic                        i_level,
    input  wire logic [ofr_pkg::TIME_W-1:0]  i_time_us,
    output ofr_pkg::t_state                  o_state,
    output ofr_pkg::t_result                 o_result
);

    logic [ofr_pkg::TIME_W-1:0] dt;
    logic [ofr_pkg::TIME_W-1:0] gap_ext;
    logic [2:0]                 kind;
    logic                       kind_ok;
    logic                       frame_ok;
    logic                       phase_idle;

    // differences wrap modulo 2^32
    assign dt         = i_time_us - i_state.last_time;
    assign gap_ext    = {16'd0, i_cfg.bit_gap};
    assign kind       = i_state.shift_frame[30:28];
    assign kind_ok    = i_cfg.listen
                        ? (kind == ofr_pkg::MSG_REQ_LO || kind == ofr_pkg::MSG_REQ_HI)
                        : (kind == ofr_pkg::MSG_RSP_LO || kind == ofr_pkg::MSG_RSP_HI);
    assign frame_ok   = !(^i_state.shift_frame) && kind_ok;
    // the unused phase code behaves as idle for polls and edges, but an arm does not leave it
    assign phase_idle = !(i_state.phase == ofr_pkg::PH_WAIT    ||
                          i_state.phase == ofr_pkg::PH_START   ||
                          i_state.phase == ofr_pkg::PH_RECV    ||
                          i_state.phase == ofr_pkg::PH_INVALID ||
                          i_state.phase == ofr_pkg::PH_DONE    ||
                          i_state.phase == ofr_pkg::PH_DELAY);

    always_comb begin
        o_state          = i_state;
        o_result.valid   = 1'b0;
        o_result.frame   = i_state.shift_frame;
        o_result.outcome = ofr_pkg::OUT_SUCCESS;

        unique case (i_cmd)
            ofr_pkg::CMD_EDGE: begin
                unique case (i_state.phase)
                    ofr_pkg::PH_WAIT: begin
                        o_state.phase     = i_level ? ofr_pkg::PH_START : ofr_pkg::PH_INVALID;
                        o_state.last_time = i_time_us;
                    end
                    ofr_pkg::PH_START: begin
                        if (dt < gap_ext && !i_level) begin
                            o_state.phase     = ofr_pkg::PH_RECV;
                            o_state.bit_count = '0;
                        end else begin
                            o_state.phase = ofr_pkg::PH_INVALID;
                        end
                        o_state.last_time = i_time_us;
                    end
                    ofr_pkg::PH_RECV: begin
                        if (dt > gap_ext) begin
                            if (i_state.bit_count < ofr_pkg::FRAME_BITS) begin
                                o_state.shift_frame = {i_state.shift_frame[30:0], !i_level};
                                o_state.bit_count   = i_state.bit_count + 6'd1;
                            end else begin
                                o_state.phase = ofr_pkg::PH_DONE;
                            end
                            o_state.last_time = i_time_us;
                        end
                    end
                    ofr_pkg::PH_INVALID, ofr_pkg::PH_DONE, ofr_pkg::PH_DELAY: ;
                    default: begin
                        // unsolicited start: passes straight through the wait phase
                        if (i_cfg.listen && i_level) begin
                            o_state.phase     = ofr_pkg::PH_START;
                            o_state.last_time = i_time_us;
                        end
                    end
                endcase
            end
            ofr_pkg::CMD_POLL: begin
                priority if (phase_idle) begin
                end else if (dt > i_cfg.timeout) begin
                    o_state.phase    = ofr_pkg::PH_IDLE;
                    o_result.valid   = 1'b1;
                    o_result.outcome = ofr_pkg::OUT_TIMEOUT;
                end else if (i_state.phase == ofr_pkg::PH_INVALID) begin
                    o_state.phase    = ofr_pkg::PH_DELAY;
                    o_result.valid   = 1'b1;
                    o_result.outcome = ofr_pkg::OUT_INVALID;
                end else if (i_state.phase == ofr_pkg::PH_DONE) begin
                    o_state.phase    = ofr_pkg::PH_DELAY;
                    o_result.valid   = 1'b1;
                    o_result.outcome = frame_ok ? ofr_pkg::OUT_SUCCESS : ofr_pkg::OUT_INVALID;
                end else if (i_state.phase == ofr_pkg::PH_DELAY && dt > i_cfg.quiet) begin
                    o_state.phase = ofr_pkg::PH_IDLE;
                end
            end
            ofr_pkg::CMD_ARM: begin
                if (i_state.phase == ofr_pkg::PH_IDLE) begin
                    o_state.phase       = ofr_pkg::PH_WAIT;
                    o_state.shift_frame = '0;
                    o_state.last_time   = i_time_us;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### verif/tb_opentherm_frame_receiver.sv
// Self-checking testbench for the OpenTherm frame receiver: random and directed edge streams.
`timescale 1ns / 1ps

module tb_opentherm_frame_receiver;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        level;
        logic [31:0] time_us;
    } t_line_evt;

    typedef struct packed {
        logic [31:0] frame;
        logic [1:0]  outcome;
    } t_report;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_cmd = ofr_pkg::CMD_EDGE;
    logic              i_level = 1'b0;
    logic [31:0]       i_time_us = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [31:0]       o_frame;
    logic [1:0]        o_outcome;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ofr_pkg::ADDR_W-1:0] paddr = '0;
    logic [ofr_pkg::DATA_W-1:0] pwdata = '0;
    logic [ofr_pkg::DATA_W-1:0] prdata;
    logic              pready;

    // receiver shadow: configuration and state
    logic              cfg_listen = 1'b0;
    logic [15:0]       cfg_gap = ofr_pkg::RST_BIT_GAP;
    logic [31:0]       cfg_timeout = ofr_pkg::RST_TIMEOUT;
    logic [31:0]       cfg_quiet = ofr_pkg::RST_QUIET;
    ofr_pkg::t_phase   rx_phase = ofr_pkg::PH_IDLE;
    logic [31:0]       rx_last = '0;
    logic [31:0]       rx_frame = '0;
    logic [5:0]        rx_bits = '0;

    t_line_evt         events_pending[$];
    t_report           reports_due[$];
    t_line_evt         evt_head;
    bit                evt_taken = 1'b0;
    bit                calm = 1'b0;
    bit                hold_req = 1'b0;
    int unsigned       hold_left = 0;
    int unsigned       errors = 0;
    int unsigned       cycle_count = 0;
    logic [31:0]       gen_now = '0;
    logic [31:0]       dir_t;

    opentherm_frame_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_level     (i_level),
        .i_time_us   (i_time_us),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_frame     (o_frame),
        .o_outcome   (o_outcome),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit frame_good(input logic [31:0] f);
        if (^f)
            return 1'b0;
        if (cfg_listen)
            return f[30:28] == ofr_pkg::MSG_REQ_LO || f[30:28] == ofr_pkg::MSG_REQ_HI;
        return f[30:28] == ofr_pkg::MSG_RSP_LO || f[30:28] == ofr_pkg::MSG_RSP_HI;
    endfunction

    task automatic receiver_step(input logic [1:0] cmd, input logic lvl, input logic [31:0] t);
        logic [31:0] dt;
        t_report     rep;
        dt = t - rx_last;
        rep.frame = rx_frame;
        case (cmd)
            ofr_pkg::CMD_EDGE: begin
                if (rx_phase == ofr_pkg::PH_IDLE) begin
                    if (cfg_listen && lvl)
                        rx_phase = ofr_pkg::PH_WAIT;
                    else
                        return;
                end
                case (rx_phase)
                    ofr_pkg::PH_WAIT: begin
                        rx_phase = lvl ? ofr_pkg::PH_START : ofr_pkg::PH_INVALID;
                        rx_last = t;
                    end
                    ofr_pkg::PH_START: begin
                        if (dt < cfg_gap && !lvl) begin
                            rx_phase = ofr_pkg::PH_RECV;
                            rx_bits = '0;
                        end else begin
                            rx_phase = ofr_pkg::PH_INVALID;
                        end
                        rx_last = t;
                    end
                    ofr_pkg::PH_RECV: begin
                        if (dt > cfg_gap) begin
                            if (rx_bits < ofr_pkg::FRAME_BITS) begin
                                rx_frame = {rx_frame[30:0], ~lvl};
                                rx_bits = rx_bits + 1'b1;
                            end else begin
                                rx_phase = ofr_pkg::PH_DONE;
                            end
                            rx_last = t;
                        end
                    end
                    default: ;
                endcase
            end
            ofr_pkg::CMD_POLL: begin
                if (rx_phase == ofr_pkg::PH_IDLE)
                    return;
                // timeout wins over every other report, delay phase included
                if (dt > cfg_timeout) begin
                    rx_phase = ofr_pkg::PH_IDLE;
                    rep.outcome = ofr_pkg::OUT_TIMEOUT;
                    reports_due.push_back(rep);
                end else if (rx_phase == ofr_pkg::PH_INVALID) begin
                    rx_phase = ofr_pkg::PH_DELAY;
                    rep.outcome = ofr_pkg::OUT_INVALID;
                    reports_due.push_back(rep);
                end else if (rx_phase == ofr_pkg::PH_DONE) begin
                    rx_phase = ofr_pkg::PH_DELAY;
                    rep.outcome = frame_good(rx_frame) ? ofr_pkg::OUT_SUCCESS
                                                       : ofr_pkg::OUT_INVALID;
                    reports_due.push_back(rep);
                end else if (rx_phase == ofr_pkg::PH_DELAY && dt > cfg_quiet) begin
                    rx_phase = ofr_pkg::PH_IDLE;
                end
            end
            ofr_pkg::CMD_ARM: begin
                if (rx_phase == ofr_pkg::PH_IDLE) begin
                    rx_phase = ofr_pkg::PH_WAIT;
                    rx_frame = '0;
                    rx_last = t;
                end
            end
            default: ;
        endcase
    endtask

    task automatic match_report(input logic [31:0] frame, input logic [1:0] outcome);
        t_report want;
        if (reports_due.size() == 0) begin
            $display("%0t: report with none due, expected nothing, actual frame %h outcome %0d",
                     $time, frame, outcome);
            errors++;
            return;
        end
        want = reports_due.pop_front();
        if (frame !== want.frame) begin
            $display("%0t: frame mismatch, expected %h, actual %h", $time, want.frame, frame);
            errors++;
        end
        if (outcome !== want.outcome) begin
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, want.outcome, outcome);
            errors++;
        end
    endtask

    // transfers are taken and checked on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            receiver_step(i_cmd, i_level, i_time_us);
            evt_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall)
            match_report(o_frame, o_outcome);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || evt_taken) begin
            evt_taken = 1'b0;
            if (events_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
                evt_head = events_pending.pop_front();
                i_in_valid <= 1'b1;
                i_cmd <= evt_head.cmd;
                i_level <= evt_head.level;
                i_time_us <= evt_head.time_us;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && $urandom_range(0, 99) < 33;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_event(input logic [1:0] cmd, input logic lvl, input logic [31:0] t);
        t_line_evt ev;
        ev.cmd = cmd;
        ev.level = lvl;
        ev.time_us = t;
        events_pending.push_back(ev);
    endtask

    task automatic wait_idle();
        while (events_pending.size() != 0 || i_in_valid || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            ofr_pkg::REG_LISTEN:  cfg_listen = value[0];
            ofr_pkg::REG_BIT_GAP: cfg_gap = value[15:0];
            ofr_pkg::REG_TIMEOUT: cfg_timeout = value;
            ofr_pkg::REG_QUIET:   cfg_quiet = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic listen, input logic [15:0] gap,
                              input logic [31:0] tmo, input logic [31:0] quiet);
        wait_idle();
        write_reg(ofr_pkg::REG_LISTEN, {31'b0, listen});
        write_reg(ofr_pkg::REG_BIT_GAP, {16'b0, gap});
        write_reg(ofr_pkg::REG_TIMEOUT, tmo);
        write_reg(ofr_pkg::REG_QUIET, quiet);
    endtask

    // span after the last progress that takes the block out of its delay
    function automatic logic [31:0] release_span();
        return (cfg_quiet < cfg_timeout ? cfg_quiet : cfg_timeout) + 32'd1;
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int unsigned r;
        w = $urandom;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            if (cfg_listen)
                w[30:28] = $urandom_range(0, 1) ? ofr_pkg::MSG_REQ_HI : ofr_pkg::MSG_REQ_LO;
            else
                w[30:28] = $urandom_range(0, 1) ? ofr_pkg::MSG_RSP_HI : ofr_pkg::MSG_RSP_LO;
            w[31] = ^w[30:0];
        end else if (r < 8) begin
            w[31] = ~^w[30:0];
        end
        return w;
    endfunction

    task automatic send_frame(input logic [31:0] word);
        logic [31:0] t;
        int          cut_at;
        t = gen_now;
        cut_at = ($urandom_range(0, 9) == 0 && cfg_timeout != '1) ? $urandom_range(0, 31) : -1;
        if (!cfg_listen || $urandom_range(0, 3) == 0) begin
            push_event(ofr_pkg::CMD_ARM, 1'($urandom_range(0, 1)), t);
            t += $urandom_range(1, 2000);
        end
        push_event(ofr_pkg::CMD_EDGE, 1'b1, t);
        if (cfg_gap != 0)
            t += $urandom_range(0, cfg_gap - 1);
        push_event(ofr_pkg::CMD_EDGE, 1'b0, t);
        for (int b = 31; b >= 0; b--) begin
            if (b == cut_at) begin
                // line goes dead mid-frame
                t += cfg_timeout + 32'd1;
                push_event(ofr_pkg::CMD_POLL, 1'b0, t);
                gen_now = t + $urandom_range(1, 5000);
                return;
            end
            // bit-boundary transition, too close to count
            if ($urandom_range(0, 1))
                push_event(ofr_pkg::CMD_EDGE, 1'($urandom_range(0, 1)),
                           t + $urandom_range(0, cfg_gap));
            t += cfg_gap + 32'd1 + $urandom_range(0, cfg_gap);
            push_event(ofr_pkg::CMD_EDGE, ~word[b], t);
            if ($urandom_range(0, 9) == 0)
                push_event(ofr_pkg::CMD_POLL, 1'($urandom_range(0, 1)),
                           t + $urandom_range(0, cfg_gap));
        end
        t += cfg_gap + 32'd1 + $urandom_range(0, cfg_gap);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, t);
        push_event(ofr_pkg::CMD_POLL, 1'($urandom_range(0, 1)),
                   t + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3000)));
        push_event(ofr_pkg::CMD_POLL, 1'b0, t + release_span());
        gen_now = t + release_span() + $urandom_range(1, 5000);
    endtask

    task automatic line_noise();
        int unsigned n;
        logic [31:0] t;
        n = $urandom_range(3, 12);
        for (int k = 0; k < n; k++) begin
            t = ($urandom_range(0, 7) == 0) ? $urandom
                                            : gen_now + $urandom_range(0, 2 * cfg_gap + 2);
            push_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), t);
            gen_now = t;
        end
        push_event(ofr_pkg::CMD_POLL, 1'b0, gen_now + release_span());
        push_event(ofr_pkg::CMD_POLL, 1'b1, gen_now + release_span());
        gen_now += release_span() + $urandom_range(1, 5000);
    endtask

    task automatic arm_and_expire();
        if (cfg_timeout == '1)
            return;
        push_event(ofr_pkg::CMD_ARM, 1'($urandom_range(0, 1)), gen_now);
        push_event(ofr_pkg::CMD_POLL, 1'b0, gen_now + cfg_timeout + 32'd1);
        gen_now += cfg_timeout + 32'd1 + $urandom_range(1, 1000);
    endtask

    task automatic run_mix(input int unsigned n_frames);
        int unsigned sent;
        int unsigned r;
        sent = 0;
        while (sent < n_frames) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_frame(pick_word());
                sent++;
            end else if (r < 9) begin
                line_noise();
            end else begin
                arm_and_expire();
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: responses only, gap 750
        dir_t = 32'hFFFF_FF00;
        push_event(ofr_pkg::CMD_POLL, 1'b0, 32'h0);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, 32'h10);
        push_event(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF);
        push_event(ofr_pkg::CMD_ARM, 1'b0, dir_t);
        push_event(ofr_pkg::CMD_POLL, 1'b1, dir_t + 32'h200);
        push_event(ofr_pkg::CMD_EDGE, 1'b0, dir_t + 32'h300);
        push_event(ofr_pkg::CMD_ARM, 1'b1, dir_t + 32'h310);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 32'h400);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 32'h300 + 100001);
        dir_t += 200000;
        push_event(ofr_pkg::CMD_ARM, 1'b0, dir_t);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, dir_t + 5);
        push_event(ofr_pkg::CMD_EDGE, 1'b0, dir_t + 755);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 755 + 1000001);
        dir_t += 3000000;
        push_event(ofr_pkg::CMD_ARM, 1'b0, dir_t);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, dir_t + 1);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, dir_t + 100);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 200);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 300);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 100 + 1000001);
        dir_t += 5000000;
        push_event(ofr_pkg::CMD_ARM, 1'b0, dir_t);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 1000001);
        dir_t += 2000000;
        push_event(ofr_pkg::CMD_ARM, 1'b0, dir_t);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, dir_t);
        push_event(ofr_pkg::CMD_EDGE, 1'b0, dir_t + 749);
        push_event(ofr_pkg::CMD_EDGE, 1'b0, dir_t + 1500);
        push_event(ofr_pkg::CMD_EDGE, 1'b1, dir_t + 2250);
        push_event(ofr_pkg::CMD_POLL, 1'b0, dir_t + 1500 + 1000001);

        set_config(1'b1, ofr_pkg::RST_BIT_GAP, ofr_pkg::RST_TIMEOUT, ofr_pkg::RST_QUIET);
        calm = 1'b1;
        gen_now = $urandom;
        send_frame(32'h0000_0000);
        send_frame(32'hFFFF_FFFF);
        run_mix(9);

        set_config(1'b0, 16'd0, 32'd0, 32'd0);
        calm = 1'b0;
        run_mix(4);

        set_config(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        run_mix(5);

        set_config(1'b0, 16'($urandom_range(100, 3000)), $urandom_range(20000, 200000),
                   32'hFFFF_FFFF);
        run_mix(5);

        // long output hold-off while reports keep coming
        set_config(1'b0, ofr_pkg::RST_BIT_GAP, 32'd10, 32'd50);
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++) begin
            push_event(ofr_pkg::CMD_ARM, 1'b0, gen_now);
            push_event(ofr_pkg::CMD_POLL, 1'b0, gen_now + 11 + $urandom_range(0, 100));
            gen_now += 1000;
        end

        set_config(1'($urandom_range(0, 1)), ofr_pkg::RST_BIT_GAP, ofr_pkg::RST_TIMEOUT,
                   ofr_pkg::RST_QUIET);
        run_mix(5);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
